[sv/ird_pkg.sv]
// Shared types and constants of the infrared pulse-distance decoder.
`timescale 1ns / 1ps

package ird_pkg;

   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 32;
   localparam int QUEUE_DEPTH = 2;

   // register map, byte address = 4 * index
   typedef enum logic [2:0] {
      REG_HDR_MARK   = 3'd0,
      REG_HDR_SPACE  = 3'd1,
      REG_BIT_COUNT  = 3'd2,
      REG_ONE_MARK   = 3'd3,
      REG_ONE_SPACE  = 3'd4,
      REG_ZERO_MARK  = 3'd5,
      REG_ZERO_SPACE = 3'd6,
      REG_STOP_MARK  = 3'd7
   } ird_reg_type;

   typedef enum logic [2:0] {
      PH_SKIP   = 3'd0,
      PH_HMARK  = 3'd1,
      PH_HSPACE = 3'd2,
      PH_BMARK  = 3'd3,
      PH_BSPACE = 3'd4,
      PH_STOP   = 3'd5,
      PH_DONE   = 3'd6,
      PH_FAIL   = 3'd7
   } ird_phase_type;

   typedef struct packed {
      logic [15:0] interval_ticks;
      logic        frame_last;
   } ird_req_type;

   typedef struct packed {
      logic        decoded_ok;
      logic [31:0] code_value;
   } ird_rsp_type;

   // tick window of one timing: lo <= ticks <= hi
   typedef struct packed {
      logic [9:0] lo;
      logic [9:0] hi;
   } ird_window_type;

   typedef struct packed {
      ird_window_type hdr_mark;
      ird_window_type hdr_space;
      ird_window_type one_mark;
      ird_window_type one_space;
      ird_window_type zero_mark;
      ird_window_type zero_space;
      ird_window_type stop_mark;
   } ird_windows_type;

   typedef struct packed {
      logic       no_header;
      logic       no_stop;
      logic [5:0] bit_count;
   } ird_mode_type;

   // bit marks are not classified here; the back end matches the held mark
   typedef struct packed {
      logic hdr_mark;
      logic hdr_space;
      logic one_space;
      logic zero_space;
      logic stop_mark;
   } ird_match_type;

   typedef struct packed {
      ird_match_type hit;
      logic [15:0]   ticks;
      logic          last;
   } ird_class_type;

   // windows top out far below 32767, so long intervals never hit
   function automatic logic in_window(input logic [15:0] ticks, input ird_window_type w);
      return (ticks >= 16'(w.lo)) && (ticks <= 16'(w.hi));
   endfunction

endpackage

[sv/ird_csr.sv]
// Register file: timing registers, readback and precomputed tick windows.
`timescale 1ns / 1ps

module ird_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [ird_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [ird_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [ird_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                               pready,
   output ird_pkg::ird_windows_type           windows,
   output ird_pkg::ird_mode_type              mode
);
   import ird_pkg::*;

   // ceil(2^19 / 25); exact floor for every quotient over the 15-bit range
   localparam logic [14:0] RECIP_25 = 15'd20972;
   localparam int          RECIP_SH = 19;

   logic [14:0] hdr_mark_ff, hdr_space_ff, one_mark_ff, one_space_ff;
   logic [14:0] zero_mark_ff, zero_space_ff, stop_mark_ff;
   logic [5:0]  bit_count_ff;
   ird_windows_type windows_ff;
   ird_window_type  wr_window;
   ird_reg_type     wr_index;
   ird_reg_type     rd_index;
   logic            wr_en;
   logic [14:0]     wr_us;

   // us*3/200 .. us*5/200+1, with /200 done as >>3 then reciprocal of 25
   function automatic ird_window_type calc_window(input logic [14:0] us);
      logic [16:0] x3;
      logic [17:0] x5;
      logic [14:0] y3;
      logic [14:0] y5;
      logic [29:0] p3;
      logic [29:0] p5;
      ird_window_type w;
      x3   = 17'(us) * 17'd3;
      x5   = 18'(us) * 18'd5;
      y3   = 15'(x3 >> 3);
      y5   = 15'(x5 >> 3);
      p3   = 30'(y3) * 30'(RECIP_25);
      p5   = 30'(y5) * 30'(RECIP_25);
      w.lo = 10'(p3 >> RECIP_SH);
      w.hi = 10'(p5 >> RECIP_SH) + 10'd1;
      return w;
   endfunction

   assign pready    = 1'b1;
   assign wr_en     = psel & penable & pwrite & pready;
   assign wr_index  = ird_reg_type'(paddr[CSR_ADDR_W-1:2]);
   assign rd_index  = ird_reg_type'(paddr[CSR_ADDR_W-1:2]);
   assign wr_us     = pwdata[14:0];
   assign wr_window = calc_window(wr_us);

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_mark_ff           <= 15'd9000;
         hdr_space_ff          <= 15'd4500;
         bit_count_ff          <= 6'd32;
         one_mark_ff           <= 15'd560;
         one_space_ff          <= 15'd1690;
         zero_mark_ff          <= 15'd560;
         zero_space_ff         <= 15'd560;
         stop_mark_ff          <= 15'd560;
         windows_ff.hdr_mark   <= calc_window(15'd9000);
         windows_ff.hdr_space  <= calc_window(15'd4500);
         windows_ff.one_mark   <= calc_window(15'd560);
         windows_ff.one_space  <= calc_window(15'd1690);
         windows_ff.zero_mark  <= calc_window(15'd560);
         windows_ff.zero_space <= calc_window(15'd560);
         windows_ff.stop_mark  <= calc_window(15'd560);
      end else if (wr_en) begin
         unique case (wr_index)
            REG_HDR_MARK: begin
               hdr_mark_ff         <= wr_us;
               windows_ff.hdr_mark <= wr_window;
            end
            REG_HDR_SPACE: begin
               hdr_space_ff         <= wr_us;
               windows_ff.hdr_space <= wr_window;
            end
            REG_BIT_COUNT: begin
               bit_count_ff <= pwdata[5:0];
            end
            REG_ONE_MARK: begin
               one_mark_ff         <= wr_us;
               windows_ff.one_mark <= wr_window;
            end
            REG_ONE_SPACE: begin
               one_space_ff         <= wr_us;
               windows_ff.one_space <= wr_window;
            end
            REG_ZERO_MARK: begin
               zero_mark_ff         <= wr_us;
               windows_ff.zero_mark <= wr_window;
            end
            REG_ZERO_SPACE: begin
               zero_space_ff         <= wr_us;
               windows_ff.zero_space <= wr_window;
            end
            REG_STOP_MARK: begin
               stop_mark_ff         <= wr_us;
               windows_ff.stop_mark <= wr_window;
            end
         endcase
      end
   end

   always_comb begin
      unique case (rd_index)
         REG_HDR_MARK:   prdata = CSR_DATA_W'(hdr_mark_ff);
         REG_HDR_SPACE:  prdata = CSR_DATA_W'(hdr_space_ff);
         REG_BIT_COUNT:  prdata = CSR_DATA_W'(bit_count_ff);
         REG_ONE_MARK:   prdata = CSR_DATA_W'(one_mark_ff);
         REG_ONE_SPACE:  prdata = CSR_DATA_W'(one_space_ff);
         REG_ZERO_MARK:  prdata = CSR_DATA_W'(zero_mark_ff);
         REG_ZERO_SPACE: prdata = CSR_DATA_W'(zero_space_ff);
         REG_STOP_MARK:  prdata = CSR_DATA_W'(stop_mark_ff);
      endcase
   end

   assign windows        = windows_ff;
   assign mode.no_header = (hdr_mark_ff == 15'd0);
   assign mode.no_stop   = (stop_mark_ff == 15'd0);
   assign mode.bit_count = bit_count_ff;

endmodule

[sv/ird_front.sv]
// Front end: takes intervals and classifies them against the header, space and stop tick windows.
`timescale 1ns / 1ps

module ird_front (
   input  logic                       req_valid,
   output logic                       req_ready,
   input  ird_pkg::ird_req_type       req_data,
   input  ird_pkg::ird_windows_type   windows,
   input  logic                       q_full,
   output logic                       q_push,
   output ird_pkg::ird_class_type     q_wdata
);
   import ird_pkg::*;

   logic [15:0] t;

   assign t         = req_data.interval_ticks;
   assign req_ready = ~q_full;
   assign q_push    = req_valid & req_ready;

   assign q_wdata.last           = req_data.frame_last;
   assign q_wdata.ticks          = t;
   assign q_wdata.hit.hdr_mark   = in_window(t, windows.hdr_mark);
   assign q_wdata.hit.hdr_space  = in_window(t, windows.hdr_space);
   assign q_wdata.hit.one_space  = in_window(t, windows.one_space);
   assign q_wdata.hit.zero_space = in_window(t, windows.zero_space);
   assign q_wdata.hit.stop_mark  = in_window(t, windows.stop_mark);

endmodule

[sv/ird_queue.sv]
// Two-entry queue of classified intervals between front and back.
`timescale 1ns / 1ps

module ird_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  ird_pkg::ird_class_type  wdata,
   input  logic                    pop,
   output logic                    full,
   output logic                    not_empty,
   output ird_pkg::ird_class_type  rdata
);
   import ird_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   ird_class_type     entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign rdata     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop ? PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      case ({push, pop})
         2'b10:   count_in = CNT_W'(count_ff + 1'b1);
         2'b01:   count_in = CNT_W'(count_ff - 1'b1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

[sv/ird_back.sv]
// Back end: frame sequencer, bit shifter and registered result stage.
`timescale 1ns / 1ps

module ird_back #(
   parameter int VALUE_BITS = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_not_empty,
   input  ird_pkg::ird_class_type   q_rdata,
   output logic                     q_pop,
   input  ird_pkg::ird_mode_type    mode,
   input  ird_pkg::ird_windows_type windows,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output ird_pkg::ird_rsp_type     rsp_data
);
   import ird_pkg::*;

   ird_phase_type         phase_ff, phase_in;
   logic [5:0]            bits_ff, bits_in;
   logic [VALUE_BITS-1:0] shift_ff, shift_in;
   logic [15:0]           held_mark_ff, held_mark_in;
   logic                  held_one, held_zero;
   logic                  rsp_valid_ff, rsp_valid_in;
   ird_rsp_type           rsp_ff, rsp_in;
   ird_phase_type         ph_pre, ph_step, ph_post;
   logic [5:0]            bits_step;
   logic [VALUE_BITS-1:0] shift_step;
   logic                  frame_ok;

   // skip the optional parts that the current mode makes empty
   function automatic ird_phase_type settle(input ird_phase_type ph, input logic [5:0] bits,
                                            input ird_mode_type m);
      ird_phase_type p;
      p = ph;
      if (p == PH_HMARK && m.no_header) p = PH_BMARK;
      if (p == PH_BMARK && bits >= m.bit_count) p = PH_STOP;
      if (p == PH_STOP && m.no_stop) p = PH_DONE;
      return p;
   endfunction

   assign q_pop = q_not_empty & (~rsp_valid_ff | rsp_ready);

   // held mark is matched against the windows in force when its space arrives
   assign held_one  = in_window(held_mark_ff, windows.one_mark);
   assign held_zero = in_window(held_mark_ff, windows.zero_mark);

   always_comb begin
      ph_pre       = settle(phase_ff, bits_ff, mode);
      ph_step      = ph_pre;
      bits_step    = bits_ff;
      shift_step   = shift_ff;
      held_mark_in = held_mark_ff;
      unique case (ph_pre)
         PH_SKIP:   ph_step = PH_HMARK;
         PH_HMARK:  ph_step = q_rdata.hit.hdr_mark ? PH_HSPACE : PH_FAIL;
         PH_HSPACE: ph_step = q_rdata.hit.hdr_space ? PH_BMARK : PH_FAIL;
         PH_BMARK: begin
            held_mark_in = q_rdata.ticks;
            ph_step      = PH_BSPACE;
         end
         PH_BSPACE: begin
            if (held_one && q_rdata.hit.one_space) begin
               shift_step = {shift_ff[VALUE_BITS-2:0], 1'b1};
               bits_step  = 6'(bits_ff + 6'd1);
               ph_step    = PH_BMARK;
            end else if (held_zero && q_rdata.hit.zero_space) begin
               shift_step = {shift_ff[VALUE_BITS-2:0], 1'b0};
               bits_step  = 6'(bits_ff + 6'd1);
               ph_step    = PH_BMARK;
            end else begin
               ph_step = PH_FAIL;
            end
         end
         PH_STOP:   ph_step = q_rdata.hit.stop_mark ? PH_DONE : PH_FAIL;
         PH_DONE:   ph_step = PH_DONE;
         PH_FAIL:   ph_step = PH_FAIL;
      endcase
      ph_post  = settle(ph_step, bits_step, mode);
      frame_ok = (ph_post == PH_DONE);

      phase_in     = phase_ff;
      bits_in      = bits_ff;
      shift_in     = shift_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_in       = rsp_ff;
      if (q_pop) begin
         if (q_rdata.last) begin
            phase_in            = PH_SKIP;
            bits_in             = '0;
            shift_in            = '0;
            rsp_valid_in        = 1'b1;
            rsp_in.decoded_ok   = frame_ok;
            rsp_in.code_value   = frame_ok ? 32'(shift_step) : 32'd0;
         end else begin
            phase_in = ph_post;
            bits_in  = bits_step;
            shift_in = shift_step;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SKIP;
         bits_ff      <= '0;
         shift_ff     <= '0;
         held_mark_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         bits_ff      <= bits_in;
         shift_ff     <= shift_in;
         rsp_valid_ff <= rsp_valid_in;
         if (q_pop) begin
            held_mark_ff <= held_mark_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[sv/ir_pulse_distance_decoder.sv]
// Top level of the infrared pulse-distance frame decoder.
`timescale 1ns / 1ps

// Channel  | Direction | Handshake              | Carries
// ---------+-----------+------------------------+-------------------------------------
// req      | in        | req_valid / req_ready  | one interval and its frame-end flag
// rsp      | out       | rsp_valid / rsp_ready  | match flag and decoded code per frame
// csr      | in/out    | psel/penable, pready=1 | eight timing and bit-count registers
//
// One interval transaction per cycle while the queue has room; a result is
// registered in the cycle after the queue hands over the frame's last interval.
// The rate is set by the back-end sequencer, which retires one queued
// interval per cycle unless a result waits on rsp. Reset is synchronous and
// restores the register defaults. The two-entry queue lets req keep flowing
// while a result waits on rsp; req_ready drops only once the queue is full.

module ir_pulse_distance_decoder #(
   parameter int VALUE_BITS = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   // interval stream
   input  logic                               req_valid,
   output logic                               req_ready,
   input  ird_pkg::ird_req_type               req_data,
   // frame results
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output ird_pkg::ird_rsp_type               rsp_data,
   // register port
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [ird_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [ird_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [ird_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                               pready
);
   import ird_pkg::*;

   ird_windows_type windows;
   ird_mode_type    mode;
   ird_class_type   q_wdata;
   ird_class_type   q_rdata;
   logic            q_push;
   logic            q_pop;
   logic            q_full;
   logic            q_not_empty;

   // register file; tick windows are worked out when a timing is written
   ird_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .windows (windows),
      .mode    (mode)
   );

   // classify each interval against the header, space and stop windows at
   // acceptance; bit marks travel as ticks and are matched in the back end
   ird_front u_front (
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .windows   (windows),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_wdata   (q_wdata)
   );

   ird_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .wdata     (q_wdata),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .rdata     (q_rdata)
   );

   // frame sequencer and result register
   ird_back #(
      .VALUE_BITS (VALUE_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_rdata     (q_rdata),
      .q_pop       (q_pop),
      .mode        (mode),
      .windows     (windows),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

   // a failed frame carries no code
   a_fail_zero_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.decoded_ok |-> rsp_data.code_value == 32'd0)
      else $error("failed frame with non-zero code");

   // a result appears only after the last interval of a frame left the queue
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(q_pop && q_rdata.last))
      else $error("result without a frame end");

   // intake stalls only when the result stage held the back end last cycle
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> $past(rsp_valid && !rsp_ready))
      else $error("intake stalled without a result back-pressure");

endmodule
